// ===== src/tpt_pkg.sv =====
package tpt_pkg;

    localparam int ADDR_W    = 16;
    localparam int OUTCOME_W = 2;
    localparam int COUNT_W   = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int OFFSET_BITS_DEF = 8;
    localparam int FRAME_W_DEF     = ADDR_W - OFFSET_BITS_DEF;
    localparam int PT_DEPTH_DEF    = PAGE_COUNT_DEF;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_TLB_HIT = 2'd0,
        OUTCOME_PT_HIT  = 2'd1,
        OUTCOME_FAULT   = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_RESOLVE
    } state_t;

    // commands from the sequencer to the page table
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } pt_cmd_t;

endpackage

// ===== src/tpt_req_if.sv =====
interface tpt_req_if;

    logic                      valid;
    logic                      ready;
    logic [tpt_pkg::ADDR_W-1:0] logical_address;

    modport source (output valid, output logical_address, input ready);
    modport sink   (input valid, input logical_address, output ready);

endinterface

// ===== src/tpt_rsp_if.sv =====
interface tpt_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [tpt_pkg::ADDR_W-1:0]    physical_address;
    logic [tpt_pkg::OUTCOME_W-1:0] outcome;
    logic [tpt_pkg::COUNT_W-1:0]   hit_count;
    logic [tpt_pkg::COUNT_W-1:0]   miss_count;
    logic [tpt_pkg::COUNT_W-1:0]   fault_count;

    modport source (
        output valid, output physical_address, output outcome,
        output hit_count, output miss_count, output fault_count,
        input  ready
    );
    modport sink (
        input  valid, input physical_address, input outcome,
        input  hit_count, input miss_count, input fault_count,
        output ready
    );

endinterface

// ===== src/tpt_tlb_cell.sv =====
module tpt_tlb_cell #(
    parameter int TAG_W   = tpt_pkg::FRAME_W_DEF,
    parameter int FRAME_W = tpt_pkg::FRAME_W_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  logic               prev_valid,
    input  logic [TAG_W-1:0]   prev_tag,
    input  logic [FRAME_W-1:0] prev_frame,
    input  logic [TAG_W-1:0]   key,
    input  logic               hit_in,
    input  logic [FRAME_W-1:0] frame_in,
    output logic               entry_valid,
    output logic [TAG_W-1:0]   entry_tag,
    output logic [FRAME_W-1:0] entry_frame,
    output logic               hit_out,
    output logic [FRAME_W-1:0] frame_out
);

    logic               valid_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= prev_valid;
        end
    end

    // take the neighbor's entry; the last cell's entry drops out
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            tag_reg   <= prev_tag;
            frame_reg <= prev_frame;
        end
    end

    // tags are unique in the chain, so an OR of the matching frame is enough
    assign match       = valid_reg && (tag_reg == key);
    assign hit_out     = hit_in | match;
    assign frame_out   = frame_in | (match ? frame_reg : '0);
    assign entry_valid = valid_reg;
    assign entry_tag   = tag_reg;
    assign entry_frame = frame_reg;

endmodule

// ===== src/tpt_page_table.sv =====
module tpt_page_table #(
    parameter int DEPTH   = tpt_pkg::PT_DEPTH_DEF,
    parameter int FRAME_W = tpt_pkg::FRAME_W_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tpt_pkg::pt_cmd_t         cmd,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [FRAME_W-1:0]       wr_frame,
    output logic                     rd_valid,
    output logic [FRAME_W-1:0]       rd_frame,
    output logic                     table_ready
);

    localparam int AW = $clog2(DEPTH);

    logic [FRAME_W:0]   pt_mem [DEPTH];
    logic [FRAME_W:0]   rd_data_reg;
    logic [AW-1:0]      clr_idx_reg;
    logic               clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    // entry is {valid, frame}; the sweep after reset zeroes every valid bit
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            pt_mem[clr_idx_reg] <= '0;
        end
        else if (cmd.wr_en)
        begin
            pt_mem[wr_addr] <= {1'b1, wr_frame};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= pt_mem[rd_addr];
        end
    end

    assign rd_valid    = rd_data_reg[FRAME_W];
    assign rd_frame    = rd_data_reg[FRAME_W-1:0];
    assign table_ready = !clearing_reg;

endmodule

// ===== src/tlb_page_table_translate_unit.sv =====
// Channel   Dir  Payload                                             Transfer
// request   in   logical_address[15:0]                               valid && ready
// response  out  physical_address, outcome, hit/miss/fault_count     valid && ready
//
// Each accepted address passes a lookup step, which searches the TLB cell chain
// and reads the page table, and a resolve step, which resolves and writes back; the next
// address can be accepted in the resolve step while the response register is free.
// After reset the page table sweeps the valid bits of all PT_DEPTH entries (256 by
// default) before the first address is taken.
// A result held in the response register stalls only the resolve step.
module tlb_page_table_translate_unit #(
    parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tpt_req_if.sink    request,
    tpt_rsp_if.source  response
);

    localparam int ADDR_W   = tpt_pkg::ADDR_W;
    localparam int COUNT_W  = tpt_pkg::COUNT_W;
    localparam int PN_W     = ADDR_W - OFFSET_BITS;
    localparam int PW       = (PN_W > 0) ? PN_W : 1;
    localparam int PT_DEPTH = (PAGE_COUNT < (1 << PW)) ? PAGE_COUNT : (1 << PW);
    localparam int PT_W     = $clog2(PT_DEPTH);
    localparam int DIV_L    = $clog2(PAGE_COUNT);
    localparam int SH       = PW + DIV_L;
    localparam int RECIP    = int'((64'd1 << SH) / PAGE_COUNT);
    localparam int PROD_W   = 2 * PW + 1;

    tpt_pkg::state_t   state_reg, state_next;
    tpt_pkg::pt_cmd_t  pt_cmd;
    tpt_pkg::outcome_t outcome_res;

    logic in_ready, in_fire, out_free, look_en, finish, fault;

    logic [PW-1:0]          in_page;
    logic [PROD_W-1:0]      prod;
    logic [PW-1:0]          page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [PW-1:0]          q_reg;
    logic [PW:0]            r_wide;
    logic [PW:0]            r_mod;
    logic [PT_W-1:0]        pidx;
    logic [PT_W-1:0]        pidx_reg;

    logic                   tlb_hit_reg;
    logic [PW-1:0]          tlb_frame_reg;
    logic                   pt_rd_valid;
    logic [PW-1:0]          pt_rd_frame;
    logic                   pt_ready;

    logic [PW-1:0]          frame_res;
    logic [PW-1:0]          next_free_reg, next_free_next;
    logic [COUNT_W-1:0]     hits_reg, hits_next;
    logic [COUNT_W-1:0]     misses_reg, misses_next;
    logic [COUNT_W-1:0]     faults_reg, faults_next;

    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]      phys_reg;
    tpt_pkg::outcome_t      outcome_reg;
    logic [COUNT_W-1:0]     hit_out_reg, miss_out_reg, fault_out_reg;

    logic                   cell_valid [TLB_ENTRIES];
    logic [PW-1:0]          cell_tag   [TLB_ENTRIES];
    logic [PW-1:0]          cell_frame [TLB_ENTRIES];
    logic                   acc_hit    [TLB_ENTRIES+1];
    logic [PW-1:0]          acc_frame  [TLB_ENTRIES+1];

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || response.ready;
    assign in_fire  = request.valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpt_pkg::ST_CLEAR:
            begin
                if (pt_ready)
                begin
                    state_next = tpt_pkg::ST_IDLE;
                end
            end
            tpt_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = tpt_pkg::ST_LOOK;
                end
            end
            tpt_pkg::ST_LOOK:
            begin
                state_next = tpt_pkg::ST_RESOLVE;
            end
            tpt_pkg::ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = in_fire ? tpt_pkg::ST_LOOK : tpt_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        look_en  = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            tpt_pkg::ST_CLEAR:
            begin
                in_ready = 1'b0;
            end
            tpt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            tpt_pkg::ST_LOOK:
            begin
                look_en = 1'b1;
            end
            tpt_pkg::ST_RESOLVE:
            begin
                finish   = out_free;
                in_ready = out_free;
            end
        endcase
    end

    assign request.ready = in_ready;

    // ---------------- address split and page index ----------------
    assign in_page = PW'(request.logical_address >> OFFSET_BITS);
    // quotient estimate by reciprocal, at most one low
    assign prod    = PROD_W'(in_page) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            page_reg   <= in_page;
            offset_reg <= request.logical_address[OFFSET_BITS-1:0];
            q_reg      <= PW'(prod >> SH);
        end
    end

    always_comb
    begin
        r_wide = (PW+1)'(page_reg) - (PW+1)'(q_reg * PAGE_COUNT);
        if (32'(r_wide) >= PAGE_COUNT)
        begin
            r_mod = r_wide - (PW+1)'(PAGE_COUNT);
        end
        else
        begin
            r_mod = r_wide;
        end
        pidx = PT_W'(r_mod);
    end

    // ---------------- TLB cell chain ----------------
    assign acc_hit[0]   = 1'b0;
    assign acc_frame[0] = '0;

    for (genvar i = 0; i < TLB_ENTRIES; i++)
    begin : g_cell
        logic          prev_valid;
        logic [PW-1:0] prev_tag;
        logic [PW-1:0] prev_frame;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
            assign prev_tag   = page_reg;
            assign prev_frame = frame_res;
        end
        else
        begin : g_body
            assign prev_valid = cell_valid[i-1];
            assign prev_tag   = cell_tag[i-1];
            assign prev_frame = cell_frame[i-1];
        end

        tpt_tlb_cell #(
            .TAG_W   (PW),
            .FRAME_W (PW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift_en    (finish && !tlb_hit_reg),
            .prev_valid  (prev_valid),
            .prev_tag    (prev_tag),
            .prev_frame  (prev_frame),
            .key         (page_reg),
            .hit_in      (acc_hit[i]),
            .frame_in    (acc_frame[i]),
            .entry_valid (cell_valid[i]),
            .entry_tag   (cell_tag[i]),
            .entry_frame (cell_frame[i]),
            .hit_out     (acc_hit[i+1]),
            .frame_out   (acc_frame[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (look_en)
        begin
            tlb_hit_reg   <= acc_hit[TLB_ENTRIES];
            tlb_frame_reg <= acc_frame[TLB_ENTRIES];
            pidx_reg      <= pidx;
        end
    end

    // ---------------- page table ----------------
    assign pt_cmd.rd_en = look_en;
    assign pt_cmd.wr_en = finish && fault;

    tpt_page_table #(
        .DEPTH   (PT_DEPTH),
        .FRAME_W (PW)
    ) u_page_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (pt_cmd),
        .rd_addr     (pidx),
        .wr_addr     (pidx_reg),
        .wr_frame    (next_free_reg),
        .rd_valid    (pt_rd_valid),
        .rd_frame    (pt_rd_frame),
        .table_ready (pt_ready)
    );

    // ---------------- resolve ----------------
    assign fault = !tlb_hit_reg && !pt_rd_valid;

    always_comb
    begin
        priority if (tlb_hit_reg)
        begin
            frame_res   = tlb_frame_reg;
            outcome_res = tpt_pkg::OUTCOME_TLB_HIT;
        end
        else if (pt_rd_valid)
        begin
            frame_res   = pt_rd_frame;
            outcome_res = tpt_pkg::OUTCOME_PT_HIT;
        end
        else
        begin
            frame_res   = next_free_reg;
            outcome_res = tpt_pkg::OUTCOME_FAULT;
        end
    end

    always_comb
    begin
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        faults_next    = faults_reg;
        next_free_next = next_free_reg;
        if (finish)
        begin
            unique case (outcome_res)
                tpt_pkg::OUTCOME_TLB_HIT:
                begin
                    if (hits_reg != tpt_pkg::COUNT_MAX)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                end
                tpt_pkg::OUTCOME_PT_HIT:
                begin
                    if (misses_reg != tpt_pkg::COUNT_MAX)
                    begin
                        misses_next = misses_reg + 1'b1;
                    end
                end
                tpt_pkg::OUTCOME_FAULT:
                begin
                    next_free_next = next_free_reg + 1'b1;
                    if (faults_reg != tpt_pkg::COUNT_MAX)
                    begin
                        faults_next = faults_reg + 1'b1;
                    end
                end
                default:
                begin
                    next_free_next = next_free_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpt_pkg::ST_CLEAR;
            next_free_reg <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            faults_reg    <= faults_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            phys_reg      <= ADDR_W'({frame_res, offset_reg});
            outcome_reg   <= outcome_res;
            hit_out_reg   <= hits_next;
            miss_out_reg  <= misses_next;
            fault_out_reg <= faults_next;
        end
    end

    assign response.valid            = out_valid_reg;
    assign response.physical_address = phys_reg;
    assign response.outcome          = outcome_reg;
    assign response.hit_count        = hit_out_reg;
    assign response.miss_count       = miss_out_reg;
    assign response.fault_count      = fault_out_reg;

`ifndef SYNTHESIS
    a_fire_enters_look: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == tpt_pkg::ST_LOOK)
        else $error("accepted address did not enter lookup");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tpt_pkg::ST_CLEAR |-> !in_ready)
        else $error("address accepted during page table sweep");

    a_fault_allocates: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && fault) |=> next_free_reg == PW'($past(next_free_reg) + 1'b1))
        else $error("page fault did not advance the free frame");

    a_one_counter_moves: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({hits_next != hits_reg, misses_next != misses_reg,
                    faults_next != faults_reg}) <= (finish ? 1 : 0))
        else $error("counters moved without a single resolved address");
`endif

endmodule

// ===== test/tlb_xlat_check.sv =====
module tlb_xlat_check
    import tpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tpt_req_if        request,
    tpt_rsp_if        response,
    output int        errors,
    output int        outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TLB_SLOTS = TLB_ENTRIES_DEF;
    localparam int PAGES     = PAGE_COUNT_DEF;
    localparam int OFF_W     = OFFSET_BITS_DEF;
    localparam int PAGE_W    = ADDR_W - OFF_W;
    localparam int FRAME_W   = FRAME_W_DEF;

    typedef struct packed {
        logic [ADDR_W-1:0]  physical_address;
        outcome_t           outcome;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
        logic [COUNT_W-1:0] fault_count;
    } xlat_t;

    // predicted translation state
    logic [PAGE_W-1:0]  tlb_tag   [TLB_SLOTS];
    logic [FRAME_W-1:0] tlb_frame [TLB_SLOTS];
    logic               tlb_live  [TLB_SLOTS];
    logic [$clog2(TLB_SLOTS)-1:0] fill_slot;
    logic [FRAME_W-1:0] pt_frame  [PAGES];
    logic               pt_live   [PAGES];
    logic [FRAME_W-1:0] free_frame;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
    logic [COUNT_W-1:0] faults;

    xlat_t pending_xlat[$];
    int    mismatches;

    assign errors = mismatches;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void tlb_fill(input logic [PAGE_W-1:0] page,
                                     input logic [FRAME_W-1:0] frame);
        tlb_tag[fill_slot]   = page;
        tlb_frame[fill_slot] = frame;
        tlb_live[fill_slot]  = 1'b1;
        fill_slot            = fill_slot + 1'b1;
    endfunction

    function automatic xlat_t translate(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               found;
        xlat_t              r;
        page  = addr[ADDR_W-1:OFF_W];
        frame = '0;
        found = 1'b0;
        // lowest matching slot wins
        for (int i = 0; i < TLB_SLOTS; i++) begin
            if (!found && tlb_live[i] && tlb_tag[i] == page) begin
                frame = tlb_frame[i];
                found = 1'b1;
            end
        end
        if (found) begin
            r.outcome = OUTCOME_TLB_HIT;
            hits      = bump(hits);
        end else if (pt_live[page % PAGES]) begin
            frame     = pt_frame[page % PAGES];
            tlb_fill(page, frame);
            r.outcome = OUTCOME_PT_HIT;
            misses    = bump(misses);
        end else begin
            frame                = free_frame;
            pt_frame[page % PAGES] = frame;
            pt_live[page % PAGES]  = 1'b1;
            tlb_fill(page, frame);
            free_frame           = free_frame + 1'b1;
            r.outcome            = OUTCOME_FAULT;
            faults               = bump(faults);
        end
        r.physical_address = {frame, addr[OFF_W-1:0]};
        r.hit_count        = hits;
        r.miss_count       = misses;
        r.fault_count      = faults;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        xlat_t want;
        if (!rst_n) begin
            for (int i = 0; i < TLB_SLOTS; i++) begin
                tlb_tag[i]   = '0;
                tlb_frame[i] = '0;
                tlb_live[i]  = 1'b0;
            end
            for (int p = 0; p < PAGES; p++) begin
                pt_frame[p] = '0;
                pt_live[p]  = 1'b0;
            end
            fill_slot  = '0;
            free_frame = '0;
            hits       = '0;
            misses     = '0;
            faults     = '0;
            pending_xlat.delete();
            mismatches = 0;
            outstanding <= 0;
        end else begin
            // retire before predicting so a same-edge transfer never matches itself
            if (response.valid && response.ready) begin
                if (pending_xlat.size() == 0) begin
                    $error("response transfer with no translation pending");
                    mismatches++;
                end else begin
                    want = pending_xlat.pop_front();
                    if (response.physical_address !== want.physical_address) begin
                        $error("physical_address: expected %h, got %h",
                               want.physical_address, response.physical_address);
                        mismatches++;
                    end
                    if (response.outcome !== want.outcome) begin
                        $error("outcome: expected %0d, got %0d",
                               want.outcome, response.outcome);
                        mismatches++;
                    end
                    if (response.hit_count !== want.hit_count) begin
                        $error("hit_count: expected %0d, got %0d",
                               want.hit_count, response.hit_count);
                        mismatches++;
                    end
                    if (response.miss_count !== want.miss_count) begin
                        $error("miss_count: expected %0d, got %0d",
                               want.miss_count, response.miss_count);
                        mismatches++;
                    end
                    if (response.fault_count !== want.fault_count) begin
                        $error("fault_count: expected %0d, got %0d",
                               want.fault_count, response.fault_count);
                        mismatches++;
                    end
                end
            end
            if (request.valid && request.ready)
                pending_xlat.push_back(translate(request.logical_address));
            outstanding <= pending_xlat.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1826;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_EVERY  = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   idle_cycles;

    // pages touched so far, for revisits that land as TLB or page-table hits
    logic [7:0] touched[$];
    logic [7:0] recent[$];
    int         calm_items;

    tpt_req_if request_ch();
    tpt_rsp_if response_ch();

    tlb_page_table_translate_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    tlb_xlat_check mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request_ch),
        .response    (response_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 ||
            (request_ch.valid && request_ch.ready) ||
            (response_ch.valid && response_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // response backpressure: mostly short stalls, a few long, some calm stretches
    initial
    begin
        int hold;
        int calm;
        int r;
        hold = 0;
        calm = 0;
        response_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                response_ch.ready <= 1'b0;
            end
            else if (calm > 0)
            begin
                calm--;
                response_ch.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    response_ch.ready <= 1'b1;
                else if (r < 93)
                begin
                    hold = $urandom_range(0, 3);
                    response_ch.ready <= 1'b0;
                end
                else if (r < 97)
                begin
                    hold = $urandom_range(10, 40);
                    response_ch.ready <= 1'b0;
                end
                else
                begin
                    calm = $urandom_range(100, 300);
                    response_ch.ready <= 1'b1;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_items > 0)
        begin
            calm_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        if (r < 98) return $urandom_range(20, 60);
        calm_items = $urandom_range(50, 150);
        return 0;
    endfunction

    function automatic logic [tpt_pkg::ADDR_W-1:0] pick_address();
        logic [7:0] page;
        logic [7:0] offset;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 50 && recent.size() > 0)
            page = recent[$urandom_range(0, recent.size() - 1)];
        else if (r < 78 && touched.size() > 0)
            page = touched[$urandom_range(0, touched.size() - 1)];
        else
            page = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r == 0)
            offset = 8'h00;
        else if (r == 1)
            offset = 8'hFF;
        else
            offset = 8'($urandom_range(0, 255));
        return {page, offset};
    endfunction

    task automatic note_page(input logic [7:0] page);
        int seen;
        seen = 0;
        foreach (touched[i])
            if (touched[i] == page)
                seen = 1;
        if (!seen)
            touched.push_back(page);
        recent.push_back(page);
        if (recent.size() > 12)
            void'(recent.pop_front());
    endtask

    task automatic send_address(input logic [tpt_pkg::ADDR_W-1:0] addr, input int gap,
                                input bit drain);
        request_ch.valid           <= 1'b1;
        request_ch.logical_address <= addr;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        note_page(addr[15:8]);
        if (drain || gap > 0)
        begin
            // drop valid and scramble the idle bus
            request_ch.valid           <= 1'b0;
            request_ch.logical_address <= tpt_pkg::ADDR_W'($urandom);
            repeat (gap) @(posedge clk);
            if (drain)
                do @(posedge clk); while (outstanding != 0);
        end
    endtask

    initial
    begin
        logic [tpt_pkg::ADDR_W-1:0] directed_addr[$];
        directed_addr = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h1234, 16'h12AB};
        // sixteen fresh pages push every earlier entry out of the TLB
        for (int p = 1; p <= 16; p++)
            directed_addr.push_back({8'(p), 8'(p * 17)});
        // evicted pages come back through the page table
        directed_addr.push_back(16'h0080);
        directed_addr.push_back(16'hFF7F);

        calm_items                 = 0;
        idle_cycles                = 0;
        rst_n                      <= 1'b0;
        request_ch.valid           <= 1'b0;
        request_ch.logical_address <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_addr[i])
            send_address(directed_addr[i], (i % 3 == 2) ? 1 : 0, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_address(pick_address(), pick_gap(), (n % DRAIN_EVERY) == DRAIN_EVERY - 1);

        request_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== tlb_page_table_translate_unit.f =====
src/tpt_pkg.sv
src/tpt_req_if.sv
src/tpt_rsp_if.sv
src/tpt_tlb_cell.sv
src/tpt_page_table.sv
src/tlb_page_table_translate_unit.sv
test/tlb_xlat_check.sv
test/tb_top.sv
